FILE: rtl/pab_pkg.sv
// ----------------------------------------------------------------------------
// Pixel alpha blend: shared types and constants
// Word layouts for both channels, command codes, pipeline latency and the
// small exact divide by 255 used at two points of the datapath.
// ----------------------------------------------------------------------------
package pab_pkg;

	// Full-scale weight (255 * 255) and saturation limits
	localparam logic [15:0] FULL_WEIGHT = 16'd65025;
	localparam logic [15:0] CHAN_MAX    = 16'hFFFF;
	localparam logic [7:0]  ALPHA_MAX   = 8'd255;

	// Command codes
	localparam logic [2:0] CMD_OVERLAY    = 3'd0;
	localparam logic [2:0] CMD_MUL_COLOR  = 3'd1;
	localparam logic [2:0] CMD_MUL_SCALAR = 3'd2;
	localparam logic [2:0] CMD_ADD        = 3'd3;
	localparam logic [2:0] CMD_TRANSITION = 3'd4;

	// Clock edges from an accepted word to its result being taken
	localparam int PIPE_LAT = 28;

	// Constant divider widths
	localparam int DIV255_IN_W  = 34;
	localparam int DIV255_OUT_W = 26;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] bottom_red;
		logic [15:0] bottom_green;
		logic [15:0] bottom_blue;
		logic [7:0]  bottom_alpha;
		logic [15:0] top_red;
		logic [15:0] top_green;
		logic [15:0] top_blue;
		logic [7:0]  top_alpha;
		logic [15:0] mix_amount;
	} pab_in_t;

	typedef struct packed {
		logic [15:0] out_red;
		logic [15:0] out_green;
		logic [15:0] out_blue;
		logic [7:0]  out_alpha;
	} pab_out_t;

	// Exact floor(x / 255) for x up to 65025
	function automatic logic [7:0] div255_small(input logic [15:0] x);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return s[15:8];
	endfunction

endpackage

FILE: rtl/pab_div255.sv
// ----------------------------------------------------------------------------
// Pixel alpha blend: pipelined divide by 255
// Two stages: a reciprocal estimate built from shifted adds, then a single
// remainder check that corrects the estimate by at most one.
// ----------------------------------------------------------------------------
module pab_div255 (
	input  logic                               clk,
	input  logic [pab_pkg::DIV255_IN_W-1:0]    x,
	output logic [pab_pkg::DIV255_OUT_W-1:0]   q
);
	import pab_pkg::*;

	localparam int PAD_W  = 25;
	localparam int PROD_W = DIV255_IN_W + PAD_W;

	logic [PROD_W-1:0]       x_ext;
	logic [PROD_W-1:0]       prod;
	logic [DIV255_IN_W-1:0]  x_s1;
	logic [DIV255_OUT_W-1:0] est_s1;
	logic [DIV255_IN_W-1:0]  rem;

	// Estimate: x * 0x01010101 / 2^32, never above the true quotient
	assign x_ext = {{PAD_W{1'b0}}, x};
	assign prod  = x_ext + (x_ext << 8) + (x_ext << 16) + (x_ext << 24);

	always_ff @(posedge clk) begin
		x_s1   <= x;
		est_s1 <= prod[32 +: DIV255_OUT_W];
	end

	// Correct: remainder x - 255*est lies below 510
	assign rem = x_s1 - {est_s1, 8'd0} + {8'd0, est_s1};

	always_ff @(posedge clk) begin
		q <= est_s1 + DIV255_OUT_W'(rem >= DIV255_IN_W'(255));
	end

endmodule

FILE: rtl/pab_div.sv
// ----------------------------------------------------------------------------
// Pixel alpha blend: pipelined restoring divider
// One quotient bit per stage, sixteen stages. The caller guarantees that the
// quotient fits in sixteen bits and that the divisor is not zero.
// ----------------------------------------------------------------------------
module pab_div (
	input  logic        clk,
	input  logic [31:0] num,
	input  logic [16:0] den,
	output logic [15:0] quo
);
	import pab_pkg::*;

	localparam int NUM_W = 32;
	localparam int DEN_W = 17;
	localparam int QUO_W = 16;

	logic [NUM_W-1:0] rem_s [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] quo_s [QUO_W];

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int B = QUO_W - 1 - i;
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic [NUM_W:0]   sub;
		logic [NUM_W:0]   trial;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		// Try to take the shifted divisor off the remainder
		assign sub   = (NUM_W+1)'(den_in) << B;
		assign trial = {1'b0, rem_in} - sub;

		always_ff @(posedge clk) begin
			den_s[i] <= den_in;
			if (!trial[NUM_W]) begin
				rem_s[i] <= trial[NUM_W-1:0];
				quo_s[i] <= quo_in | (QUO_W'(1) << B);
			end else begin
				rem_s[i] <= rem_in;
				quo_s[i] <= quo_in;
			end
		end
	end

	assign quo = quo_s[QUO_W-1];

endmodule

FILE: rtl/pixel_alpha_blend_unit.sv
// ----------------------------------------------------------------------------
// Pixel alpha blend unit
// Blends a bottom pixel with a top pixel, or scales the bottom pixel, in one
// of five modes: overlay, multiply by colour, multiply by scalar, add and
// transition.
//
// Usage:
//   Input channel: drive a word on pixel and raise start; the word is taken
//   at the rising edge where start is high and busy is low. busy is always
//   low, so a new word may be taken on every clock.
//   Output channel: done is high for exactly one cycle with the result word
//   on result; the result is taken at the edge that ends that cycle.
//   Throughput: one word per clock.
//   The latency is set by the overlay coverage divide, a sixteen-stage
//   restoring divider, followed by the channel multiply-add and two
//   pipelined divides by 255.
//   Reset: arst_n clears all valid bits at once; words in flight are dropped.
//   The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module pixel_alpha_blend_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pab_pkg::pab_in_t  pixel,
	output logic              done,
	output pab_pkg::pab_out_t result
);
	import pab_pkg::*;

	localparam int LINE_LEN = 27;
	localparam int LANES    = 4;

	// Data carried down the pipeline beside the arithmetic
	typedef struct packed {
		pab_in_t         px;
		logic [15:0]     k;
		logic [7:0]      w;
		logic [7:0]      ova;
		logic [2:0][15:0] f;
	} side_t;

	logic              accept;
	logic [LINE_LEN:1] v_s;
	side_t             side_s [1:LINE_LEN];
	side_t             side_d [1:LINE_LEN];

	logic [2:0][31:0]  kt_s2;
	logic [2:0][DIV255_OUT_W-1:0] kt1_s4;
	logic [2:0][DIV255_OUT_W-1:0] kt2_s6;
	logic [2:0][15:0]  f_calc;
	logic [2:0][15:0]  top_1;

	logic [15:0]       o_s3;
	logic [15:0]       na_s3;
	logic [31:0]       num_s4;
	logic [16:0]       den_s4;
	logic [15:0]       alna_s4;
	logic [15:0]       w255_3;
	logic [16:0]       den_raw;
	logic [15:0]       p_s20;

	logic [LANES-1:0][15:0] c_d, t_d, cp_d, cq_d;
	logic [LANES-1:0][15:0] c_s21, t_s21, cp_s21, cq_s21;
	logic [LANES-1:0][31:0] pa_s22, pb_s22;
	logic [LANES-1:0][DIV255_IN_W-1:0]  sum_s23;
	logic [LANES-1:0][DIV255_OUT_W-1:0] q1_s25;
	logic [LANES-1:0][DIV255_OUT_W-1:0] q2_s27;

	logic [15:0]       a8_scaled;
	logic [15:0]       m_sat;
	logic [15:0]       w255_20;
	logic [8:0]        add_alpha;
	logic [LANES-1:0][15:0] chan_sat;
	logic [7:0]        alpha_d;

	pab_out_t          result_q;
	logic              done_q;

	assign accept = start && !busy;
	assign busy   = 1'b0;

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s    <= '0;
			done_q <= 1'b0;
		end else begin
			v_s    <= {v_s[LINE_LEN-1:1], accept};
			done_q <= v_s[LINE_LEN];
		end
	end

	// Side line: copy forward, filling fields as they are worked out
	always_comb begin
		side_d[1]    = '0;
		side_d[1].px = pixel;
		side_d[1].k  = {8'd0, pixel.top_alpha} * {8'd0, pixel.mix_amount[7:0]};
		for (int j = 2; j <= LINE_LEN; j++) begin
			side_d[j] = side_s[j-1];
		end
		side_d[2].w   = div255_small(side_s[1].k);
		side_d[5].ova = div255_small(alna_s4);
		side_d[7].f   = f_calc;
	end

	always_ff @(posedge clk) begin
		side_s <= side_d;
	end

	// Multiply by top colour: k*t/65025 through two divides by 255
	assign top_1[0] = side_s[1].px.top_red;
	assign top_1[1] = side_s[1].px.top_green;
	assign top_1[2] = side_s[1].px.top_blue;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			kt_s2[i] <= {16'd0, side_s[1].k} * {16'd0, top_1[i]};
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_kt
		pab_div255 u_kt1 (
			.clk (clk),
			.x   ({2'b00, kt_s2[i]}),
			.q   (kt1_s4[i])
		);
		pab_div255 u_kt2 (
			.clk (clk),
			.x   ({8'd0, kt1_s4[i]}),
			.q   (kt2_s6[i])
		);
		// Factor stays within 16 bits: at most 65025 plus k*510/65025
		assign f_calc[i] = FULL_WEIGHT - side_s[6].k + kt2_s6[i][15:0];
	end

	// Overlay coverage terms
	always_ff @(posedge clk) begin
		o_s3  <= {8'd0, side_s[2].px.bottom_alpha} * {8'd0, ALPHA_MAX - side_s[2].w};
		na_s3 <= {8'd0, ALPHA_MAX - side_s[2].px.bottom_alpha}
			* {8'd0, ALPHA_MAX - side_s[2].w};
	end

	assign w255_3  = {side_s[3].w, 8'd0} - {8'd0, side_s[3].w};
	assign den_raw = {1'b0, o_s3} + {1'b0, w255_3};

	// A zero divisor only comes with a zero numerator; divide by one instead
	always_ff @(posedge clk) begin
		num_s4  <= {16'd0, FULL_WEIGHT} * {16'd0, o_s3};
		den_s4  <= (den_raw == '0) ? 17'd1 : den_raw;
		alna_s4 <= FULL_WEIGHT - na_s3;
	end

	pab_div u_div (
		.clk (clk),
		.num (num_s4),
		.den (den_s4),
		.quo (p_s20)
	);

	// Pick lane operands and weights: lane = (c*cp + t*cq) / 65025
	assign a8_scaled = {side_s[20].px.mix_amount[7:0], 8'd0}
		- {8'd0, side_s[20].px.mix_amount[7:0]};
	assign m_sat     = (side_s[20].px.mix_amount > FULL_WEIGHT) ?
		FULL_WEIGHT : side_s[20].px.mix_amount;
	assign w255_20   = {side_s[20].w, 8'd0} - {8'd0, side_s[20].w};

	always_comb begin
		c_d[0] = side_s[20].px.bottom_red;
		c_d[1] = side_s[20].px.bottom_green;
		c_d[2] = side_s[20].px.bottom_blue;
		c_d[3] = {8'd0, side_s[20].px.bottom_alpha};
		t_d[0] = side_s[20].px.top_red;
		t_d[1] = side_s[20].px.top_green;
		t_d[2] = side_s[20].px.top_blue;
		t_d[3] = {8'd0, side_s[20].px.top_alpha};
		// Alpha lane only serves transition
		cp_d[3] = FULL_WEIGHT - m_sat;
		cq_d[3] = m_sat;
		for (int l = 0; l < 3; l++) begin
			case (side_s[20].px.command)
				CMD_OVERLAY: begin
					cp_d[l] = p_s20;
					cq_d[l] = FULL_WEIGHT - p_s20;
				end
				CMD_MUL_COLOR: begin
					cp_d[l] = side_s[20].f[l];
					cq_d[l] = '0;
				end
				CMD_MUL_SCALAR: begin
					cp_d[l] = a8_scaled;
					cq_d[l] = '0;
				end
				CMD_ADD: begin
					cp_d[l] = FULL_WEIGHT;
					cq_d[l] = w255_20;
				end
				CMD_TRANSITION: begin
					cp_d[l] = FULL_WEIGHT - m_sat;
					cq_d[l] = m_sat;
				end
				default: begin
					cp_d[l] = FULL_WEIGHT;
					cq_d[l] = '0;
				end
			endcase
		end
	end

	// Lane products, sum, then two divides by 255
	always_ff @(posedge clk) begin
		c_s21  <= c_d;
		t_s21  <= t_d;
		cp_s21 <= cp_d;
		cq_s21 <= cq_d;
		for (int l = 0; l < LANES; l++) begin
			pa_s22[l]  <= {16'd0, c_s21[l]} * {16'd0, cp_s21[l]};
			pb_s22[l]  <= {16'd0, t_s21[l]} * {16'd0, cq_s21[l]};
			sum_s23[l] <= {2'b00, pa_s22[l]} + {2'b00, pb_s22[l]};
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		pab_div255 u_q1 (
			.clk (clk),
			.x   (sum_s23[l]),
			.q   (q1_s25[l])
		);
		pab_div255 u_q2 (
			.clk (clk),
			.x   ({8'd0, q1_s25[l]}),
			.q   (q2_s27[l])
		);
		// Clamp channels at full scale
		assign chan_sat[l] = (|q2_s27[l][DIV255_OUT_W-1:16]) ? CHAN_MAX : q2_s27[l][15:0];
	end

	// Select resulting opacity per mode
	assign add_alpha = {1'b0, side_s[27].px.bottom_alpha} + {1'b0, side_s[27].w};

	always_comb begin
		case (side_s[27].px.command)
			CMD_OVERLAY:    alpha_d = side_s[27].ova;
			CMD_ADD:        alpha_d = add_alpha[8] ? ALPHA_MAX : add_alpha[7:0];
			CMD_TRANSITION: alpha_d = q2_s27[3][7:0];
			default:        alpha_d = side_s[27].px.bottom_alpha;
		endcase
	end

	// Hold the result word for its strobe cycle
	always_ff @(posedge clk) begin
		result_q.out_red   <= chan_sat[0];
		result_q.out_green <= chan_sat[1];
		result_q.out_blue  <= chan_sat[2];
		result_q.out_alpha <= alpha_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/pab_checker.sv
// ----------------------------------------------------------------------------
// Pixel alpha blend: port checker
// Watches the ports of the blend unit for latency and for modes whose result
// is known directly from the input word.
// ----------------------------------------------------------------------------
module pab_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input pab_pkg::pab_in_t  pixel,
	input logic              done,
	input pab_pkg::pab_out_t result
);
	import pab_pkg::*;

	// Every result word comes from a word taken a fixed latency earlier
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without a matching input word");

	// Unused commands pass the bottom pixel through
	a_unused_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (pixel.command > CMD_TRANSITION), PIPE_LAT)
		|-> result.out_red == $past(pixel.bottom_red, PIPE_LAT)
		&& result.out_green == $past(pixel.bottom_green, PIPE_LAT)
		&& result.out_blue == $past(pixel.bottom_blue, PIPE_LAT)
		&& result.out_alpha == $past(pixel.bottom_alpha, PIPE_LAT))
		else $error("unused command altered the bottom pixel");

	// Full transition weight gives the top pixel
	a_transition_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (pixel.command == CMD_TRANSITION)
			&& (pixel.mix_amount >= FULL_WEIGHT), PIPE_LAT)
		|-> result.out_red == $past(pixel.top_red, PIPE_LAT)
		&& result.out_green == $past(pixel.top_green, PIPE_LAT)
		&& result.out_blue == $past(pixel.top_blue, PIPE_LAT)
		&& result.out_alpha == $past(pixel.top_alpha, PIPE_LAT))
		else $error("full transition did not give the top pixel");

	// Scalar multiply by zero clears the channels and keeps alpha
	a_scalar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && !busy && (pixel.command == CMD_MUL_SCALAR)
			&& (pixel.mix_amount[7:0] == 8'd0), PIPE_LAT)
		|-> result.out_red == 16'd0 && result.out_green == 16'd0
		&& result.out_blue == 16'd0
		&& result.out_alpha == $past(pixel.bottom_alpha, PIPE_LAT))
		else $error("scalar multiply by zero gave a wrong word");

endmodule

bind pixel_alpha_blend_unit pab_checker u_pab_checker (.*);
